### src/nsp_pkg.sv
// nsp_pkg: shared types, character codes and sentence kinds of the nmea sentence parser
// no dependencies; imported by every module of the block

package nsp_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int HEADER_CHARS   = 5;
   localparam int HDR_POS_W      = 3;
   localparam int DIGIT_W        = 32;
   localparam int FRAC_W         = 4;
   localparam int FIELD_NUM_W    = 5;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_F   = 8'h66;

   localparam logic [39:0] NAME_GGA = 40'h4750474741;
   localparam logic [39:0] NAME_GSA = 40'h4750475341;
   localparam logic [39:0] NAME_GSV = 40'h4750475356;
   localparam logic [39:0] NAME_RMC = 40'h4750524D43;
   localparam logic [39:0] NAME_VTG = 40'h4750565447;

   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_GGA  = 3'd1;
   localparam logic [2:0] KIND_GSA  = 3'd2;
   localparam logic [2:0] KIND_GSV  = 3'd3;
   localparam logic [2:0] KIND_RMC  = 3'd4;
   localparam logic [2:0] KIND_VTG  = 3'd5;

   localparam logic RES_FIELD = 1'b0;
   localparam logic RES_END   = 1'b1;

   typedef struct packed {
      logic                   result_kind;
      logic [2:0]             sentence_kind;
      logic [FIELD_NUM_W-1:0] field_number;
      logic [7:0]             lead_char;
      logic                   field_empty;
      logic                   value_negative;
      logic [DIGIT_W-1:0]     digit_value;
      logic [FRAC_W-1:0]      fraction_digits;
      logic                   checksum_ok;
      logic [7:0]             received_sum;
      logic [7:0]             computed_sum;
   } result_type;

   function automatic logic [2:0] classify(input logic [39:0] text);
      logic [2:0] kind;
      kind = KIND_NONE;
      if (text == NAME_GGA) kind = KIND_GGA;
      else if (text == NAME_GSA) kind = KIND_GSA;
      else if (text == NAME_GSV) kind = KIND_GSV;
      else if (text == NAME_RMC) kind = KIND_RMC;
      else if (text == NAME_VTG) kind = KIND_VTG;
      return kind;
   endfunction

endpackage

### src/nsp_in_reg.sv
// nsp_in_reg: input register holding one received byte until the parse stage takes it
// uses nsp_pkg

module nsp_in_reg
   import nsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       vld_ff;
   logic       vld_in;
   logic [7:0] data_ff;
   logic       accept;

   assign req_stall  = vld_ff & ~take;
   assign accept     = req_valid & ~req_stall;
   assign vld_in     = accept | (vld_ff & ~take);
   assign byte_valid = vld_ff;
   assign byte_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (accept) begin
         data_ff <= req_rx_byte;
      end
   end

endmodule

### src/nsp_parse_core.sv
// nsp_parse_core: sentence state and combinational parse logic for one byte per beat
// uses nsp_pkg (character codes, kinds, result_type, classify)

module nsp_parse_core
   import nsp_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] rx,
   output logic       res_valid,
   output result_type res
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_FIELDS,
      PH_SUM
   } phase_type;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
   localparam logic [VALUE_BITS-1:0] MAX_DIV   = VALUE_MAX / 10;
   localparam logic [3:0]            MAX_REM   = 4'(VALUE_MAX % 10);

   phase_type              phase_ff, phase_in;
   logic [HDR_POS_W-1:0]   hdr_pos_ff, hdr_pos_in;
   logic [39:0]            hdr_text_ff, hdr_text_in;
   logic [2:0]             kind_ff, kind_in;
   logic [7:0]             sum_ff, sum_in;
   logic [FIELD_NUM_W-1:0] field_cnt_ff, field_cnt_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic [FRAC_W-1:0]      frac_ff, frac_in;
   logic                   point_ff, point_in;
   logic                   minus_ff, minus_in;
   logic [7:0]             first_ff, first_in;
   logic                   has_ff, has_in;
   logic [1:0]             hex_cnt_ff, hex_cnt_in;
   logic [7:0]             hex_acc_ff, hex_acc_in;

   logic                   clear_all;
   logic                   start_sentence;
   logic                   is_digit;
   logic [3:0]             digit;
   logic                   saturate;
   logic [VALUE_BITS-1:0]  acc_times_ten;
   logic                   hex_ok;
   logic [3:0]             hex_val;
   logic [7:0]             hex_next;

   assign is_digit      = rx inside {[CHAR_ZERO:CHAR_NINE]};
   assign digit         = rx[3:0];
   assign saturate      = (acc_ff > MAX_DIV) || ((acc_ff == MAX_DIV) && (digit > MAX_REM));
   assign acc_times_ten = (acc_ff << 3) + (acc_ff << 1) + VALUE_BITS'(digit);
   assign hex_next      = {hex_acc_ff[3:0], hex_val};

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = rx[3:0];
      if (rx inside {[CHAR_UP_A:CHAR_UP_F]} || rx inside {[CHAR_LO_A:CHAR_LO_F]}) begin
         hex_val = 4'(rx[3:0] + 4'd9);
      end else if (!is_digit) begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      hdr_pos_in     = hdr_pos_ff;
      hdr_text_in    = hdr_text_ff;
      kind_in        = kind_ff;
      sum_in         = sum_ff;
      field_cnt_in   = field_cnt_ff;
      acc_in         = acc_ff;
      frac_in        = frac_ff;
      point_in       = point_ff;
      minus_in       = minus_ff;
      first_in       = first_ff;
      has_in         = has_ff;
      hex_cnt_in     = hex_cnt_ff;
      hex_acc_in     = hex_acc_ff;
      clear_all      = 1'b0;
      start_sentence = 1'b0;
      res_valid      = 1'b0;
      res            = '0;

      if (rx == CHAR_DOLLAR) begin
         clear_all      = 1'b1;
         start_sentence = 1'b1;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
            end
            PH_HEADER: begin
               if (rx == CHAR_STAR) begin
                  if (hdr_pos_ff < HDR_POS_W'(HEADER_CHARS)) kind_in = KIND_NONE;
                  phase_in   = PH_SUM;
                  hex_cnt_in = '0;
                  hex_acc_in = '0;
               end else begin
                  sum_in = sum_ff ^ rx;
                  if (hdr_pos_ff < HDR_POS_W'(HEADER_CHARS)) begin
                     hdr_text_in = {hdr_text_ff[31:0], rx};
                     hdr_pos_in  = hdr_pos_ff + 1'b1;
                     if (hdr_pos_ff == HDR_POS_W'(HEADER_CHARS - 1)) begin
                        kind_in = classify({hdr_text_ff[31:0], rx});
                     end
                  end else begin
                     phase_in = PH_FIELDS;
                     acc_in   = '0;
                     frac_in  = '0;
                     point_in = 1'b0;
                     minus_in = 1'b0;
                     first_in = '0;
                     has_in   = 1'b0;
                  end
               end
            end
            PH_FIELDS: begin
               if (rx == CHAR_COMMA || rx == CHAR_STAR) begin
                  res_valid           = 1'b1;
                  res.result_kind     = RES_FIELD;
                  res.sentence_kind   = kind_ff;
                  res.field_number    = field_cnt_ff;
                  res.lead_char       = has_ff ? first_ff : 8'd0;
                  res.field_empty     = ~has_ff;
                  res.value_negative  = minus_ff;
                  res.digit_value     = DIGIT_W'(acc_ff);
                  res.fraction_digits = frac_ff;
                  if (field_cnt_ff != '1) field_cnt_in = field_cnt_ff + 1'b1;
                  acc_in   = '0;
                  frac_in  = '0;
                  point_in = 1'b0;
                  minus_in = 1'b0;
                  first_in = '0;
                  has_in   = 1'b0;
                  if (rx == CHAR_COMMA) begin
                     sum_in = sum_ff ^ rx;
                  end else begin
                     phase_in   = PH_SUM;
                     hex_cnt_in = '0;
                     hex_acc_in = '0;
                  end
               end else begin
                  sum_in = sum_ff ^ rx;
                  if (!has_ff) begin
                     first_in = rx;
                     has_in   = 1'b1;
                  end
                  if (!has_ff && rx == CHAR_MINUS) begin
                     minus_in = 1'b1;
                  end else if (is_digit) begin
                     acc_in = saturate ? VALUE_MAX : acc_times_ten;
                     if (point_ff && frac_ff != '1) frac_in = frac_ff + 1'b1;
                  end else if (rx == CHAR_POINT) begin
                     point_in = 1'b1;
                  end
               end
            end
            PH_SUM: begin
               if (!hex_ok) begin
                  clear_all = 1'b1;
               end else begin
                  hex_acc_in = hex_next;
                  hex_cnt_in = hex_cnt_ff + 1'b1;
                  if (hex_cnt_ff == 2'd1) begin
                     res_valid         = 1'b1;
                     res.result_kind   = RES_END;
                     res.sentence_kind = kind_ff;
                     res.field_number  = field_cnt_ff;
                     res.checksum_ok   = (hex_next == sum_ff);
                     res.received_sum  = hex_next;
                     res.computed_sum  = sum_ff;
                     clear_all         = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (clear_all) begin
         phase_in     = start_sentence ? PH_HEADER : PH_IDLE;
         hdr_pos_in   = '0;
         hdr_text_in  = '0;
         kind_in      = KIND_NONE;
         sum_in       = '0;
         field_cnt_in = '0;
         acc_in       = '0;
         frac_in      = '0;
         point_in     = 1'b0;
         minus_in     = 1'b0;
         first_in     = '0;
         has_in       = 1'b0;
         hex_cnt_in   = '0;
         hex_acc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hdr_pos_ff   <= '0;
         hdr_text_ff  <= '0;
         kind_ff      <= KIND_NONE;
         sum_ff       <= '0;
         field_cnt_ff <= '0;
         acc_ff       <= '0;
         frac_ff      <= '0;
         point_ff     <= 1'b0;
         minus_ff     <= 1'b0;
         first_ff     <= '0;
         has_ff       <= 1'b0;
         hex_cnt_ff   <= '0;
         hex_acc_ff   <= '0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         hdr_pos_ff   <= hdr_pos_in;
         hdr_text_ff  <= hdr_text_in;
         kind_ff      <= kind_in;
         sum_ff       <= sum_in;
         field_cnt_ff <= field_cnt_in;
         acc_ff       <= acc_in;
         frac_ff      <= frac_in;
         point_ff     <= point_in;
         minus_ff     <= minus_in;
         first_ff     <= first_in;
         has_ff       <= has_in;
         hex_cnt_ff   <= hex_cnt_in;
         hex_acc_ff   <= hex_acc_in;
      end
   end

endmodule

### src/nsp_out_reg.sv
// nsp_out_reg: result register that holds one result beat until the receiver takes it
// uses nsp_pkg (result_type)

module nsp_out_reg
   import nsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type data_in,
   input  logic       rsp_stall,
   output logic       out_free,
   output logic       rsp_valid,
   output result_type data_out
);

   logic       vld_ff;
   logic       vld_in;
   result_type data_ff;

   assign out_free  = ~vld_ff | ~rsp_stall;
   assign vld_in    = load | (vld_ff & rsp_stall);
   assign rsp_valid = vld_ff;
   assign data_out  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule

### src/nmea_sentence_parser.sv
// nmea_sentence_parser: top level, input register, parse stage and result register
// uses nsp_pkg, nsp_in_reg, nsp_parse_core, nsp_out_reg

// The parser takes one received byte per beat and sustains one byte per clock cycle
// while the result register can take a result: a byte waits in the input register, is
// parsed against the sentence state, and any field or end result lands in the result
// register, which holds it until it is taken. The result register is where stalls start;
// while it keeps an untaken result, bytes keep flowing as long as they produce none.
// VALUE_BITS sets the saturation width of the digit accumulator; the reported value
// is its low 32 bits.

module nmea_sentence_parser
   import nsp_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_result_kind,
   output logic [2:0]             rsp_sentence_kind,
   output logic [FIELD_NUM_W-1:0] rsp_field_number,
   output logic [7:0]             rsp_lead_char,
   output logic                   rsp_field_empty,
   output logic                   rsp_value_negative,
   output logic [DIGIT_W-1:0]     rsp_digit_value,
   output logic [FRAC_W-1:0]      rsp_fraction_digits,
   output logic                   rsp_checksum_ok,
   output logic [7:0]             rsp_received_sum,
   output logic [7:0]             rsp_computed_sum
);

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       out_free;
   logic       fire;
   logic       res_valid;
   result_type res;
   result_type rsp_data;

   assign fire = byte_valid & (out_free | ~res_valid);

   nsp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (fire),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   nsp_parse_core #(
      .VALUE_BITS (VALUE_BITS)
   ) u_parse_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .rx        (byte_data),
      .res_valid (res_valid),
      .res       (res)
   );

   nsp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire & res_valid),
      .data_in   (res),
      .rsp_stall (rsp_stall),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .data_out  (rsp_data)
   );

   assign rsp_result_kind     = rsp_data.result_kind;
   assign rsp_sentence_kind   = rsp_data.sentence_kind;
   assign rsp_field_number    = rsp_data.field_number;
   assign rsp_lead_char       = rsp_data.lead_char;
   assign rsp_field_empty     = rsp_data.field_empty;
   assign rsp_value_negative  = rsp_data.value_negative;
   assign rsp_digit_value     = rsp_data.digit_value;
   assign rsp_fraction_digits = rsp_data.fraction_digits;
   assign rsp_checksum_ok     = rsp_data.checksum_ok;
   assign rsp_received_sum    = rsp_data.received_sum;
   assign rsp_computed_sum    = rsp_data.computed_sum;

endmodule

### dv/nmea_result_checker.sv
// nmea_result_checker: watches both channels of the nmea sentence parser, predicts
// field and sentence-end results from accepted bytes and compares them beat by beat
// depends on nsp_pkg for the result layout, character codes and sentence kinds
`timescale 1ns / 1ps

module nmea_result_checker
   import nsp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_result_kind,
   input  logic [2:0]             rsp_sentence_kind,
   input  logic [FIELD_NUM_W-1:0] rsp_field_number,
   input  logic [7:0]             rsp_lead_char,
   input  logic                   rsp_field_empty,
   input  logic                   rsp_value_negative,
   input  logic [DIGIT_W-1:0]     rsp_digit_value,
   input  logic [FRAC_W-1:0]      rsp_fraction_digits,
   input  logic                   rsp_checksum_ok,
   input  logic [7:0]             rsp_received_sum,
   input  logic [7:0]             rsp_computed_sum,
   output int                     fail_count,
   output int                     pending_results
);

   typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_FIELDS, PH_SUM} parse_phase_type;

   localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_BITS_DEF) - 64'd1;

   parse_phase_type phase;
   logic [2:0]   hdr_count;
   logic [39:0]  hdr_text;
   logic [2:0]   kind;
   logic [7:0]   xor_sum;
   logic [4:0]   field_count;
   logic [63:0]  value_acc;
   logic [3:0]   frac_count;
   logic         point_seen;
   logic         minus_seen;
   logic [7:0]   lead;
   logic         has_chars;
   int           hex_count;
   logic [7:0]   hex_acc;

   result_type   sentence_results[$];

   task automatic clear_field();
      value_acc = '0;
      frac_count = '0;
      point_seen = 1'b0;
      minus_seen = 1'b0;
      lead = '0;
      has_chars = 1'b0;
   endtask

   task automatic restart();
      phase = PH_IDLE;
      hdr_count = '0;
      hdr_text = '0;
      kind = KIND_NONE;
      xor_sum = '0;
      field_count = '0;
      hex_count = 0;
      hex_acc = '0;
      clear_field();
   endtask

   task automatic parse_byte(input logic [7:0] b);
      result_type  r;
      logic [63:0] d;
      logic [7:0]  nib;
      logic        is_hex;
      if (b == CHAR_DOLLAR) begin
         restart();
         phase = PH_HEADER;
         return;
      end
      case (phase)
         PH_IDLE: ;
         PH_HEADER: begin
            if (b == CHAR_STAR) begin
               if (hdr_count < HEADER_CHARS) kind = KIND_NONE;
               phase = PH_SUM;
               hex_count = 0;
               hex_acc = '0;
            end else begin
               xor_sum ^= b;
               if (hdr_count < HEADER_CHARS) begin
                  hdr_text = {hdr_text[31:0], b};
                  hdr_count++;
                  if (hdr_count == HEADER_CHARS) begin
                     case (hdr_text)
                        NAME_GGA: kind = KIND_GGA;
                        NAME_GSA: kind = KIND_GSA;
                        NAME_GSV: kind = KIND_GSV;
                        NAME_RMC: kind = KIND_RMC;
                        NAME_VTG: kind = KIND_VTG;
                        default:  kind = KIND_NONE;
                     endcase
                  end
               end else begin
                  phase = PH_FIELDS;
                  clear_field();
               end
            end
         end
         PH_FIELDS: begin
            if (b == CHAR_COMMA || b == CHAR_STAR) begin
               r = '0;
               r.result_kind = RES_FIELD;
               r.sentence_kind = kind;
               r.field_number = field_count;
               r.lead_char = has_chars ? lead : 8'h00;
               r.field_empty = !has_chars;
               r.value_negative = minus_seen;
               r.digit_value = value_acc[DIGIT_W-1:0];
               r.fraction_digits = frac_count;
               sentence_results.push_back(r);
               if (field_count < 5'd31) field_count++;
               clear_field();
               if (b == CHAR_COMMA) begin
                  xor_sum ^= b;
               end else begin
                  phase = PH_SUM;
                  hex_count = 0;
                  hex_acc = '0;
               end
               return;
            end
            xor_sum ^= b;
            if (!has_chars) begin
               lead = b;
               has_chars = 1'b1;
               if (b == CHAR_MINUS) begin
                  minus_seen = 1'b1;
                  return;
               end
            end
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               d = 64'(b - CHAR_ZERO);
               if (value_acc > (VALUE_MAX - d) / 64'd10) value_acc = VALUE_MAX;
               else value_acc = value_acc * 64'd10 + d;
               if (point_seen && frac_count < 4'd15) frac_count++;
            end else if (b == CHAR_POINT) begin
               point_seen = 1'b1;
            end
         end
         PH_SUM: begin
            is_hex = 1'b1;
            nib = '0;
            if (b >= CHAR_ZERO && b <= CHAR_NINE) nib = b - CHAR_ZERO;
            else if (b >= CHAR_UP_A && b <= CHAR_UP_F) nib = b - CHAR_UP_A + 8'd10;
            else if (b >= CHAR_LO_A && b <= CHAR_LO_F) nib = b - CHAR_LO_A + 8'd10;
            else is_hex = 1'b0;
            if (!is_hex) begin
               restart();
               return;
            end
            hex_acc = {hex_acc[3:0], nib[3:0]};
            hex_count++;
            if (hex_count == 2) begin
               r = '0;
               r.result_kind = RES_END;
               r.sentence_kind = kind;
               r.field_number = field_count;
               r.checksum_ok = (hex_acc == xor_sum);
               r.received_sum = hex_acc;
               r.computed_sum = xor_sum;
               sentence_results.push_back(r);
               restart();
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         restart();
         sentence_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sentence_results.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with nothing expected, actual kind %0h field %0d",
                        $time, rsp_result_kind, rsp_field_number);
            end else begin
               want = sentence_results.pop_front();
               check_field("result_kind", 32'(want.result_kind), 32'(rsp_result_kind));
               check_field("sentence_kind", 32'(want.sentence_kind),
                           32'(rsp_sentence_kind));
               check_field("field_number", 32'(want.field_number), 32'(rsp_field_number));
               check_field("lead_char", 32'(want.lead_char), 32'(rsp_lead_char));
               check_field("field_empty", 32'(want.field_empty), 32'(rsp_field_empty));
               check_field("value_negative", 32'(want.value_negative),
                           32'(rsp_value_negative));
               check_field("digit_value", want.digit_value, rsp_digit_value);
               check_field("fraction_digits", 32'(want.fraction_digits),
                           32'(rsp_fraction_digits));
               check_field("checksum_ok", 32'(want.checksum_ok), 32'(rsp_checksum_ok));
               check_field("received_sum", 32'(want.received_sum), 32'(rsp_received_sum));
               check_field("computed_sum", 32'(want.computed_sum), 32'(rsp_computed_sum));
            end
         end
         if (req_valid && !req_stall) parse_byte(req_rx_byte);
      end
      pending_results = sentence_results.size();
   end

endmodule

### dv/testbench.sv
// testbench: drives sentence bytes into nmea_sentence_parser with random gaps and stalls,
// directed corner sentences first, then random well-formed and broken sentences
// depends on nsp_pkg, nmea_sentence_parser and nmea_result_checker
`timescale 1ns / 1ps

module testbench
   import nsp_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 230;
   localparam int HOLD_CYCLES = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_rx_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_result_kind;
   logic [2:0]             rsp_sentence_kind;
   logic [FIELD_NUM_W-1:0] rsp_field_number;
   logic [7:0]             rsp_lead_char;
   logic                   rsp_field_empty;
   logic                   rsp_value_negative;
   logic [DIGIT_W-1:0]     rsp_digit_value;
   logic [FRAC_W-1:0]      rsp_fraction_digits;
   logic                   rsp_checksum_ok;
   logic [7:0]             rsp_received_sum;
   logic [7:0]             rsp_computed_sum;
   int                     fail_count;
   int                     pending_results;

   int                     cycle_count = 0;
   int                     bytes_sent = 0;
   int                     send_idle_pct = 0;
   int                     recv_idle_pct = 0;
   int                     hold_requests = 0;
   int                     holds_done = 0;
   int                     hold_left = 0;
   logic [7:0]             line_bytes[$];

   nmea_sentence_parser dut (.*);

   nmea_result_checker checker_inst (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver side: random stalls, or a long hold when one is requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic send_sentence(input string body, input bit good);
      logic [7:0] sum;
      sum = 8'h00;
      for (int i = 0; i < body.len(); i++) sum ^= body[i];
      if (!good) sum = ~sum;
      send_text({"$", body, "*", $sformatf("%02X", sum)});
   endtask

   function automatic logic [7:0] random_content_byte();
      logic [7:0] c;
      do c = $urandom_range(0, 255);
      while (c == CHAR_DOLLAR || c == CHAR_STAR || c == CHAR_COMMA);
      return c;
   endfunction

   function automatic logic [7:0] random_digit();
      return ($urandom_range(0, 3) == 0) ? CHAR_NINE : 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
   endfunction

   task automatic add_fields();
      int n_fields;
      int n_int;
      int n_frac;
      n_fields = ($urandom_range(0, 14) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 12);
      for (int k = 0; k < n_fields; k++) begin
         if (k > 0) line_bytes.push_back(CHAR_COMMA);
         case ($urandom_range(0, 9))
            0: ;
            1: line_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
            2: repeat ($urandom_range(1, 4)) line_bytes.push_back(random_content_byte());
            default: begin
               if ($urandom_range(0, 3) == 0) line_bytes.push_back(CHAR_MINUS);
               n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
               repeat (n_int) line_bytes.push_back(random_digit());
               if ($urandom_range(0, 1) == 1) begin
                  line_bytes.push_back(CHAR_POINT);
                  n_frac = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18)
                                                       : $urandom_range(0, 5);
                  repeat (n_frac) begin
                     line_bytes.push_back(random_digit());
                     if ($urandom_range(0, 29) == 0) line_bytes.push_back(CHAR_POINT);
                  end
               end
            end
         endcase
      end
   endtask

   task automatic make_sentence();
      logic [39:0] hdr;
      logic [7:0]  sum;
      string       hex;
      int          hlen;
      int          keep;
      line_bytes.delete();
      line_bytes.push_back(CHAR_DOLLAR);
      case ($urandom_range(0, 6))
         0: hdr = NAME_GGA;
         1: hdr = NAME_GSA;
         2: hdr = NAME_GSV;
         3: hdr = NAME_RMC;
         4: hdr = NAME_VTG;
         default: for (int i = 0; i < 5; i++) hdr[i*8 +: 8] = 8'($urandom_range(8'h41, 8'h5A));
      endcase
      hlen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4) : HEADER_CHARS;
      for (int i = 0; i < hlen; i++) line_bytes.push_back(hdr[(4 - i) * 8 +: 8]);
      if (hlen == HEADER_CHARS) begin
         case ($urandom_range(0, 19))
            0: ;
            1: begin
               line_bytes.push_back(random_content_byte());
               add_fields();
            end
            default: begin
               line_bytes.push_back(CHAR_COMMA);
               add_fields();
            end
         endcase
      end
      sum = 8'h00;
      for (int i = 1; i < line_bytes.size(); i++) sum ^= line_bytes[i];
      line_bytes.push_back(CHAR_STAR);
      if ($urandom_range(0, 9) == 0) sum ^= 8'($urandom_range(1, 255));
      hex = ($urandom_range(0, 1) == 1) ? $sformatf("%02x", sum) : $sformatf("%02X", sum);
      line_bytes.push_back(hex[0]);
      line_bytes.push_back(hex[1]);
      case ($urandom_range(0, 14))
         0: line_bytes[line_bytes.size() - 1 - $urandom_range(0, 1)] =
               8'($urandom_range(8'h67, 8'h7A));
         1: begin
            keep = $urandom_range(2, line_bytes.size() - 1);
            while (line_bytes.size() > keep) void'(line_bytes.pop_back());
         end
         default: ;
      endcase
   endtask

   initial begin
      int start;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // ignored outside a sentence
      push_byte(8'hFF);
      push_byte(8'h00);
      send_sentence("GPVTG,-4294967295.5.0,,Z", 1'b1);
      send_sentence("GPGGA,99999999999,1.2345678901234567", 1'b0);
      // star inside the header, then star right after a full header
      send_sentence("GPGS", 1'b1);
      send_sentence("GPRMC", 1'b1);
      // sentence cut short by a new dollar
      send_text("$GPGSA,12");
      send_sentence("GPGSV,x-1", 1'b1);
      // non-hex checksum digit abandons the sentence
      send_text("$GPGGA,1*G0");
      send_text("$GPGSA,,*3f");

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct <= 79;
            end
            1: begin
               send_idle_pct = 79;
               recv_idle_pct <= 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         if (p == 1) begin
            req_valid <= 1'b0;
            while (pending_results != 0) @(negedge clock);
         end else begin
            hold_requests <= hold_requests + 1;
         end
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) begin
            if ($urandom_range(0, 5) == 0) begin
               repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
            end
            make_sentence();
            foreach (line_bytes[i]) push_byte(line_bytes[i]);
         end
      end
      req_valid <= 1'b0;

      while (pending_results != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
